### design/rv32i_subset_instruction_decoder_core_defines.svh
// assertion macros for the instruction decoder core
`ifndef RV32I_SUBSET_INSTRUCTION_DECODER_CORE_DEFINES_SVH
`define RV32I_SUBSET_INSTRUCTION_DECODER_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while reset is held
`define RVD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// next-cycle implication, sampled on i_clk, off while reset is held
`define RVD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

### design/rvd_pkg.sv
// shared types, opcodes and helper functions for the instruction decoder
`timescale 1ns / 1ps

package rvd_pkg;

    localparam int unsigned InstrWidth = 32;
    localparam int unsigned RegIdxWidth = 5;
    localparam int unsigned ImmWidth = 21;
    localparam int unsigned AluOpWidth = 4;
    localparam int unsigned OutDataWidth = 48;

    // major opcodes of the supported subset
    localparam logic [6:0] OP_RTYPE  = 7'h33;
    localparam logic [6:0] OP_ITYPE  = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;

    // funct7 pattern that selects sub / sra on register-register ops
    localparam logic [6:0] F7_ALT = 7'h20;

    typedef enum logic [AluOpWidth-1:0] {
        ALU_ADD  = 4'd0,
        ALU_SUB  = 4'd1,
        ALU_AND  = 4'd2,
        ALU_OR   = 4'd3,
        ALU_XOR  = 4'd4,
        ALU_SLT  = 4'd5,
        ALU_SLL  = 4'd6,
        ALU_SRL  = 4'd7,
        ALU_SLTU = 4'd8,
        ALU_SRA  = 4'd9
    } t_alu_op;

    // funct3 encodings of the alu group
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;

    // one decoded result
    typedef struct packed {
        logic                          is_jump;
        logic                          branch_not_equal;
        logic                          is_branch;
        logic                          use_immediate;
        logic                          write_memory;
        logic                          read_memory;
        logic                          write_register;
        t_alu_op                       alu_operation;
        logic signed [ImmWidth-1:0]    immediate;
        logic [RegIdxWidth-1:0]        dest_reg;
        logic [RegIdxWidth-1:0]        src_reg_b;
        logic [RegIdxWidth-1:0]        src_reg_a;
    } t_dec_out;

    // alu operation from funct3 and the alternate-encoding bit
    function automatic t_alu_op alu_from_funct3(input logic [2:0] f3, input logic alt,
                                                input logic is_reg);
        t_alu_op op;
        case (f3)
            F3_ADD:  op = (is_reg && alt) ? ALU_SUB : ALU_ADD;
            F3_SLL:  op = ALU_SLL;
            F3_SLT:  op = ALU_SLT;
            F3_SLTU: op = ALU_SLTU;
            F3_XOR:  op = ALU_XOR;
            F3_SR:   op = alt ? ALU_SRA : ALU_SRL;
            F3_OR:   op = ALU_OR;
            default: op = ALU_AND;
        endcase
        return op;
    endfunction

endpackage

### design/rv32i_subset_instruction_decoder_core.sv
// top level of the rv32i subset instruction decoder: input and result registers
// Usage:
//   The slave stream takes one raw 32-bit instruction word per beat on
//   s_axis_tdata. The master stream gives one decoded beat per instruction
//   on m_axis_tdata: register indices, sign-extended immediate, alu code
//   and control flags, in the same order as the words went in.
//   A word taken from the slave stream lands in the input register, is
//   decoded by a short block of logic and is caught in the result
//   register, where m_axis_tvalid rises.
//   Throughput is one instruction per cycle; the pipeline of two registers
//   advances whenever the result register is empty or being drained.
//   When the receiver holds m_axis_tready low the result beat stays put,
//   the input register keeps its word, and s_axis_tready drops only once
//   both registers are full, so no beat is lost or repeated.
//   A synchronous active-low reset empties both registers by clearing their
//   valid flags; the held word and the decoded result are not reset.
`timescale 1ns / 1ps

module rv32i_subset_instruction_decoder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // instruction [31:0]
    input  logic [rvd_pkg::InstrWidth-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // src_reg_a [4:0], src_reg_b [9:5], dest_reg [14:10], immediate [35:15],
    // alu_operation [39:36], write_register [40], read_memory [41],
    // write_memory [42], use_immediate [43], is_branch [44],
    // branch_not_equal [45], is_jump [46], zero [47]
    output logic [rvd_pkg::OutDataWidth-1:0]  m_axis_tdata
);
    import rvd_pkg::*;

    `include "rv32i_subset_instruction_decoder_core_defines.svh"

    logic                  r_in_valid;
    logic [InstrWidth-1:0] r_instr;
    logic                  r_out_valid;
    t_dec_out              r_dec;
    t_dec_out              n_dec;
    logic                  in_beat;
    logic                  advance;

    // pipeline advance and handshake
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_instr <= s_axis_tdata;
        end
    end

    // decode logic
    rvd_decode u_decode (
        .i_instr (r_instr),
        .o_dec   (n_dec)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_dec <= n_dec;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_dec};

    // checks
    `RVD_ASSERT_NEXT(a_in_beat_loads, in_beat, r_in_valid)
    `RVD_ASSERT_NEXT(a_stage_moves, r_in_valid && advance, r_out_valid)
    `RVD_ASSERT_NOW(a_one_kind, r_out_valid,
        $onehot0({r_dec.read_memory, r_dec.write_memory, r_dec.is_branch, r_dec.is_jump}))
    `RVD_ASSERT_NOW(a_branch_no_wb, r_out_valid && r_dec.is_branch,
        !r_dec.write_register && !r_dec.use_immediate)

endmodule

### design/rvd_decode.sv
// combinational field extraction and control decode for one instruction word
`timescale 1ns / 1ps

module rvd_decode (
    input  logic [rvd_pkg::InstrWidth-1:0] i_instr,
    output rvd_pkg::t_dec_out              o_dec
);
    import rvd_pkg::*;

    logic [6:0] opcode;
    logic [2:0] funct3;
    logic [6:0] funct7;

    assign opcode = i_instr[6:0];
    assign funct3 = i_instr[14:12];
    assign funct7 = i_instr[31:25];

    // decode by major opcode; unknown opcodes clear all but the register index fields
    always_comb begin
        o_dec                  = '0;
        o_dec.src_reg_a        = i_instr[19:15];
        o_dec.src_reg_b        = i_instr[24:20];
        o_dec.dest_reg         = i_instr[11:7];
        o_dec.alu_operation    = ALU_ADD;
        case (opcode)
            OP_RTYPE: begin
                o_dec.write_register = 1'b1;
                o_dec.alu_operation  = alu_from_funct3(funct3, funct7 == F7_ALT, 1'b1);
            end
            OP_ITYPE: begin
                o_dec.write_register = 1'b1;
                o_dec.use_immediate  = 1'b1;
                o_dec.immediate      = {{9{i_instr[31]}}, i_instr[31:20]};
                o_dec.alu_operation  = alu_from_funct3(funct3, i_instr[30], 1'b0);
            end
            OP_LOAD: begin
                o_dec.write_register = 1'b1;
                o_dec.read_memory    = 1'b1;
                o_dec.use_immediate  = 1'b1;
                o_dec.immediate      = {{9{i_instr[31]}}, i_instr[31:20]};
            end
            OP_STORE: begin
                o_dec.write_memory   = 1'b1;
                o_dec.use_immediate  = 1'b1;
                o_dec.immediate      = {{9{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
            end
            OP_BRANCH: begin
                o_dec.is_branch        = 1'b1;
                o_dec.branch_not_equal = funct3[0];
                o_dec.alu_operation    = ALU_SUB;
                o_dec.immediate        = {{8{i_instr[31]}}, i_instr[31], i_instr[7],
                                          i_instr[30:25], i_instr[11:8], 1'b0};
            end
            OP_JAL: begin
                o_dec.write_register = 1'b1;
                o_dec.use_immediate  = 1'b1;
                o_dec.is_jump        = 1'b1;
                o_dec.immediate      = {i_instr[31], i_instr[19:12], i_instr[20],
                                        i_instr[30:21], 1'b0};
            end
            default: begin
                o_dec.write_register = 1'b0;
            end
        endcase
    end

endmodule
